@@ rtl/kwl_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kwl_pkg
// Shared types, constants and helper functions of the keyword token lexer.
// ----------------------------------------------------------------------------
package kwl_pkg;

  // Internal position counter width, and width of the position ports
  localparam int unsigned POS_WIDTH     = 16;
  localparam int unsigned OUT_POS_WIDTH = 16;
  localparam int unsigned TAG_WIDTH     = 5;

  // Depth of the token record queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Source bytes with a meaning of their own
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // Token tags
  typedef enum logic [TAG_WIDTH-1:0] {
    TAG_ILLEGAL = 5'd0,
    TAG_EOF     = 5'd1,
    TAG_IDENT   = 5'd2,
    TAG_INT     = 5'd3,
    TAG_FN      = 5'd4,
    TAG_LET     = 5'd5,
    TAG_ASSIGN  = 5'd6,
    TAG_PLUS    = 5'd7,
    TAG_COMMA   = 5'd8,
    TAG_SEMI    = 5'd9,
    TAG_LPAREN  = 5'd10,
    TAG_RPAREN  = 5'd11,
    TAG_LBRACE  = 5'd12,
    TAG_RBRACE  = 5'd13,
    TAG_BANG    = 5'd14,
    TAG_MINUS   = 5'd15,
    TAG_STAR    = 5'd16,
    TAG_SLASH   = 5'd17,
    TAG_LT      = 5'd18,
    TAG_GT      = 5'd19
  } tag_e;

  // One token as it leaves the block
  typedef struct packed {
    tag_e                     tag;
    logic [OUT_POS_WIDTH-1:0] start_pos;
    logic [OUT_POS_WIDTH-1:0] end_pos;
  } token_t;

  // Tokens caused by one source byte: one, or two when two is set
  typedef struct packed {
    logic   two;
    token_t tok0;
    token_t tok1;
  } record_t;

  // Single-byte token lookup; anything unlisted is illegal
  function automatic tag_e punct_tag(input logic [7:0] c);
    tag_e t;
    case (c)
      8'h3D:   t = TAG_ASSIGN;
      8'h2B:   t = TAG_PLUS;
      8'h2C:   t = TAG_COMMA;
      8'h3B:   t = TAG_SEMI;
      8'h28:   t = TAG_LPAREN;
      8'h29:   t = TAG_RPAREN;
      8'h7B:   t = TAG_LBRACE;
      8'h7D:   t = TAG_RBRACE;
      8'h21:   t = TAG_BANG;
      8'h2D:   t = TAG_MINUS;
      8'h2A:   t = TAG_STAR;
      8'h2F:   t = TAG_SLASH;
      8'h3C:   t = TAG_LT;
      8'h3E:   t = TAG_GT;
      default: t = TAG_ILLEGAL;
    endcase
    return t;
  endfunction

  // Characters of the keyword "fn"
  function automatic logic [7:0] kw_fn_char(input logic idx);
    return idx ? 8'h6E : 8'h66;
  endfunction

  // Characters of the keyword "let"
  function automatic logic [7:0] kw_let_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h6C;
      2'd1:    c = 8'h65;
      2'd2:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Saturating position increment
  function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] p);
    return (p == {POS_WIDTH{1'b1}}) ? p : p + POS_WIDTH'(1);
  endfunction

  // Low bits of a position as carried on the ports
  function automatic logic [OUT_POS_WIDTH-1:0] out_pos(input logic [POS_WIDTH-1:0] p);
    logic [63:0] ext;
    ext = 64'(p);
    return ext[OUT_POS_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/keyword_token_lexer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// keyword_token_lexer
// Streaming tokenizer: source bytes in, tagged tokens with positions out.
//
// Input channel: drive ch_i and push; a byte is taken on a clock edge with
// push high and full low. One byte per cycle is accepted for as long as the
// record queue has room.
// Result channel: while empty is low the oldest token sits on tag_o,
// start_pos_o, end_pos_o and last_o; pop high on an edge takes it. last_o
// marks the final token caused by one byte.
// Path: the record for a byte is written into the four-entry queue on the edge
// that takes the byte, and loads from there into the output stage.
// Throughput: one byte per cycle in while full is low; one token per cycle
// out while pop is high, so a byte that closes a run and is itself a token
// yields two. Continuing bytes and white space give no token of their own.
// Stall: if pop is held low the queue fills and full rises after five
// token-bearing bytes (one in the output stage, four queued); nothing is lost.
// Reset: rst_ni low clears the run state, position and queue at once.
// ----------------------------------------------------------------------------
module keyword_token_lexer
  import kwl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [7:0]          ch_i,
  output logic                     empty,
  input  wire logic                pop,
  output logic [TAG_WIDTH-1:0]     tag_o,
  output logic [OUT_POS_WIDTH-1:0] start_pos_o,
  output logic [OUT_POS_WIDTH-1:0] end_pos_o,
  output logic                     last_o
);

  logic    accept;
  record_t rec;
  logic    rec_valid;
  logic    q_valid;
  record_t q_data;
  logic    q_pop;

  assign accept = push && !full;

  // Classification and run tracking
  kwl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .ch_i        (ch_i),
    .rec_o       (rec),
    .rec_valid_o (rec_valid)
  );

  // Record queue
  kwl_fifo u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (rec_valid),
    .wr_data_i  (rec),
    .full_o     (full),
    .rd_pop_i   (q_pop),
    .rd_valid_o (q_valid),
    .rd_data_o  (q_data)
  );

  // Token output
  kwl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rd_valid_i  (q_valid),
    .rd_data_i   (q_data),
    .rd_pop_o    (q_pop),
    .pop         (pop),
    .empty       (empty),
    .tag_o       (tag_o),
    .start_pos_o (start_pos_o),
    .end_pos_o   (end_pos_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire

@@ rtl/kwl_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kwl_front
// Classifies each source byte, tracks the open run and the position, and
// writes the tokens that the byte causes as one record into the queue.
// ----------------------------------------------------------------------------
module kwl_front
  import kwl_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] ch_i,
  output record_t         rec_o,
  output logic            rec_valid_o
);

  typedef enum logic [1:0] {
    MODE_NONE  = 2'd0,
    MODE_IDENT = 2'd1,
    MODE_INT   = 2'd2
  } mode_e;

  mode_e                mode_q, mode_d;
  logic [POS_WIDTH-1:0] run_start_q, run_start_d;
  logic [POS_WIDTH-1:0] pos_q, pos_d;
  logic [2:0]           run_len_q, run_len_d;
  logic [1:0]           hits_q, hits_d;

  logic                 word_ch, digit_ch, is_space;
  logic                 cont_ident, cont_int, run_open;
  logic [POS_WIDTH-1:0] pos_inc;
  logic [2:0]           base_len, id_len;
  logic [1:0]           base_hits, id_hits;
  logic                 fn_ok, let_ok;
  tag_e                 run_tag;
  token_t               run_tok, byte_tok;
  logic                 byte_tok_valid;

  // Byte classes
  always_comb begin
    word_ch  = (ch_i == CH_UNDER)
            || (ch_i >= CH_UPPER_A && ch_i <= CH_UPPER_Z)
            || (ch_i >= CH_LOWER_A && ch_i <= CH_LOWER_Z);
    digit_ch = (ch_i >= CH_ZERO && ch_i <= CH_NINE);
    is_space = (ch_i == CH_SPACE) || (ch_i == CH_TAB)
            || (ch_i == CH_CR) || (ch_i == CH_LF);
  end

  assign cont_ident = (mode_q == MODE_IDENT) && word_ch;
  assign cont_int   = (mode_q == MODE_INT) && digit_ch;
  assign run_open   = (mode_q == MODE_IDENT) || (mode_q == MODE_INT);
  assign pos_inc    = sat_inc(pos_q);

  // Keyword tracking for an identifier byte, on top of the open run or a fresh one
  always_comb begin
    base_len  = cont_ident ? run_len_q : 3'd0;
    base_hits = cont_ident ? hits_q : 2'b11;
    fn_ok     = (base_len < 3'd2) && (ch_i == kw_fn_char(base_len[0]));
    let_ok    = (base_len < 3'd3) && (ch_i == kw_let_char(base_len[1:0]));
    id_len    = (base_len < 3'd4) ? base_len + 3'd1 : base_len;
    id_hits   = base_hits & {let_ok, fn_ok};
  end

  // Tag of the run being closed
  always_comb begin
    if (mode_q == MODE_INT) begin
      run_tag = TAG_INT;
    end else if (run_len_q == 3'd2 && hits_q[0]) begin
      run_tag = TAG_FN;
    end else if (run_len_q == 3'd3 && hits_q[1]) begin
      run_tag = TAG_LET;
    end else begin
      run_tag = TAG_IDENT;
    end
    run_tok.tag       = run_tag;
    run_tok.start_pos = out_pos(run_start_q);
    run_tok.end_pos   = out_pos(pos_q);
  end

  // Token of the byte itself: end of input, punctuation or illegal
  always_comb begin
    if (ch_i == CH_NUL) begin
      byte_tok.tag     = TAG_EOF;
      byte_tok.end_pos = out_pos(pos_q);
    end else begin
      byte_tok.tag     = punct_tag(ch_i);
      byte_tok.end_pos = out_pos(pos_inc);
    end
    byte_tok.start_pos = out_pos(pos_q);
    byte_tok_valid     = !cont_ident && !cont_int
                      && ((ch_i == CH_NUL) || (!is_space && !word_ch && !digit_ch));
  end

  // Record for the queue
  always_comb begin
    rec_o.two   = run_open && byte_tok_valid;
    rec_o.tok0  = run_open ? run_tok : byte_tok;
    rec_o.tok1  = byte_tok;
    rec_valid_o = accept_i && !cont_ident && !cont_int && (run_open || byte_tok_valid);
  end

  // Run state and position update
  always_comb begin
    mode_d      = mode_q;
    run_start_d = run_start_q;
    pos_d       = pos_q;
    run_len_d   = run_len_q;
    hits_d      = hits_q;
    if (cont_ident) begin
      run_len_d = id_len;
      hits_d    = id_hits;
      pos_d     = pos_inc;
    end else if (cont_int) begin
      run_len_d = (run_len_q < 3'd4) ? run_len_q + 3'd1 : run_len_q;
      pos_d     = pos_inc;
    end else begin
      mode_d      = MODE_NONE;
      run_start_d = '0;
      run_len_d   = 3'd0;
      hits_d      = 2'b11;
      if (ch_i == CH_NUL) begin
        pos_d = '0;
      end else if (word_ch) begin
        mode_d      = MODE_IDENT;
        run_start_d = pos_q;
        run_len_d   = id_len;
        hits_d      = id_hits;
        pos_d       = pos_inc;
      end else if (digit_ch) begin
        mode_d      = MODE_INT;
        run_start_d = pos_q;
        run_len_d   = 3'd1;
        pos_d       = pos_inc;
      end else begin
        pos_d = pos_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_NONE;
      run_start_q <= '0;
      pos_q       <= '0;
      run_len_q   <= 3'd0;
      hits_q      <= 2'b11;
    end else if (accept_i) begin
      mode_q      <= mode_d;
      run_start_q <= run_start_d;
      pos_q       <= pos_d;
      run_len_q   <= run_len_d;
      hits_q      <= hits_d;
    end
  end

endmodule
`default_nettype wire

@@ rtl/kwl_fifo.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kwl_fifo
// Short queue of token records between the front and the back.
// ----------------------------------------------------------------------------
module kwl_fifo
  import kwl_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    wr_valid_i,
  input  wire record_t wr_data_i,
  output logic         full_o,
  input  wire logic    rd_pop_i,
  output logic         rd_valid_o,
  output record_t      rd_data_o
);

  record_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q;
  logic                  do_wr, do_rd;

  assign full_o     = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
  assign rd_valid_o = (count_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && !full_o;
  assign do_rd      = rd_pop_i && rd_valid_o;

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                              : wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0
                                                              : rd_ptr_q + FIFO_PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + FIFO_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - FIFO_CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/kwl_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// kwl_back
// Takes records from the queue and presents their tokens one at a time on
// the result ports, marking the final token of each record.
// ----------------------------------------------------------------------------
module kwl_back
  import kwl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                rd_valid_i,
  input  wire record_t             rd_data_i,
  output logic                     rd_pop_o,
  input  wire logic                pop,
  output logic                     empty,
  output logic [TAG_WIDTH-1:0]     tag_o,
  output logic [OUT_POS_WIDTH-1:0] start_pos_o,
  output logic [OUT_POS_WIDTH-1:0] end_pos_o,
  output logic                     last_o
);

  record_t cur_q;
  logic    cur_valid_q;
  logic    second_q;
  logic    finish, advance;
  token_t  shown;

  // Current token
  assign shown       = second_q ? cur_q.tok1 : cur_q.tok0;
  assign tag_o       = shown.tag;
  assign start_pos_o = shown.start_pos;
  assign end_pos_o   = shown.end_pos;
  assign last_o      = second_q || !cur_q.two;
  assign empty       = !cur_valid_q;

  // Step to the second token, or load the next record
  assign advance  = cur_valid_q && pop && !second_q && cur_q.two;
  assign finish   = !cur_valid_q || (pop && last_o);
  assign rd_pop_o = finish && rd_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      second_q    <= 1'b0;
    end else if (advance) begin
      second_q <= 1'b1;
    end else if (finish) begin
      cur_valid_q <= rd_valid_i;
      second_q    <= 1'b0;
    end
  end

  // Record payload
  always_ff @(posedge clk_i) begin
    if (rd_pop_o) begin
      cur_q <= rd_data_i;
    end
  end

endmodule
`default_nettype wire

@@ tb/sv/tb_keyword_token_lexer.sv @@
// ----------------------------------------------------------------------------
// tb_keyword_token_lexer
// Self-checking bench for the keyword token lexer. Source bytes are pushed
// into the block while a predictor in the bench tracks runs, keywords and the
// saturating position, and queues the tokens each byte should produce. Every
// popped token is compared field by field with the oldest queued one. Directed
// sequences cover keywords, runs, every single-byte token, end of input and
// positions along a longer line; random token-shaped text with noise then runs
// under several idle and stall mixes, plus a long output hold-off.
// ----------------------------------------------------------------------------
module tb_keyword_token_lexer;
  timeunit 1ns;
  timeprecision 1ps;

  import kwl_pkg::*;

  localparam int unsigned HALF_PERIOD  = 10;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned BYTES_PER_PHASE = 180;

  // Kind of run the predictor has open
  typedef enum logic [1:0] {
    RUN_NONE   = 2'd0,
    RUN_WORD   = 2'd1,
    RUN_NUMBER = 2'd2
  } run_e;

  // One token as seen on the result ports
  typedef struct packed {
    tag_e                     tag;
    logic [OUT_POS_WIDTH-1:0] start_pos;
    logic [OUT_POS_WIDTH-1:0] end_pos;
    logic                     last;
  } tok_t;

  logic                     clk_i  = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     push   = 1'b0;
  logic [7:0]               ch_i   = 8'h00;
  logic                     pop    = 1'b0;
  logic                     full;
  logic                     empty;
  logic [TAG_WIDTH-1:0]     tag_o;
  logic [OUT_POS_WIDTH-1:0] start_pos_o;
  logic [OUT_POS_WIDTH-1:0] end_pos_o;
  logic                     last_o;

  // Predictor state
  run_e                 run_kind = RUN_NONE;
  logic [POS_WIDTH-1:0] run_from = '0;
  logic [POS_WIDTH-1:0] cur_pos  = '0;
  logic [2:0]           run_len  = '0;
  logic [1:0]           kw_live  = 2'b11;
  tok_t                 token_q[$];

  // Idling control and bookkeeping
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_req  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycles    = 0;
  int unsigned bytes_sent     = 0;
  int unsigned tokens_checked = 0;
  int unsigned two_token_bytes = 0;
  int unsigned errors    = 0;

  string near_kw[] = '{"f", "fnn", "le", "lett", "l", "Fn", "lEt", "_fn", "n", "lefn", "et"};
  string punct_set = "=+,;(){}!-*/<>";
  string space_set = " \t\r\n";

  keyword_token_lexer dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .ch_i       (ch_i),
    .empty      (empty),
    .pop        (pop),
    .tag_o      (tag_o),
    .start_pos_o(start_pos_o),
    .end_pos_o  (end_pos_o),
    .last_o     (last_o)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic logic word_byte(input logic [7:0] c);
    return c == CH_UNDER || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
           (c >= CH_LOWER_A && c <= CH_LOWER_Z);
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  // Position advance, held at the top value
  function automatic logic [POS_WIDTH-1:0] pos_next(input logic [POS_WIDTH-1:0] p);
    return (&p) ? p : p + POS_WIDTH'(1);
  endfunction

  function automatic tag_e byte_tag(input logic [7:0] c);
    case (c)
      "=":     return TAG_ASSIGN;
      "+":     return TAG_PLUS;
      ",":     return TAG_COMMA;
      ";":     return TAG_SEMI;
      "(":     return TAG_LPAREN;
      ")":     return TAG_RPAREN;
      "{":     return TAG_LBRACE;
      "}":     return TAG_RBRACE;
      "!":     return TAG_BANG;
      "-":     return TAG_MINUS;
      "*":     return TAG_STAR;
      "/":     return TAG_SLASH;
      "<":     return TAG_LT;
      ">":     return TAG_GT;
      default: return TAG_ILLEGAL;
    endcase
  endfunction

  // Track whether the word so far still spells fn or let
  function automatic void note_letter(input logic [7:0] c);
    logic [7:0] fn_ch;
    logic [7:0] let_ch;
    fn_ch = (run_len == 3'd0) ? "f" : "n";
    case (run_len)
      3'd0:    let_ch = "l";
      3'd1:    let_ch = "e";
      default: let_ch = "t";
    endcase
    if (!(run_len < 3'd2 && c == fn_ch)) kw_live[0] = 1'b0;
    if (!(run_len < 3'd3 && c == let_ch)) kw_live[1] = 1'b0;
    if (run_len < 3'd4) run_len++;
  endfunction

  function automatic tag_e closed_run_tag();
    if (run_kind == RUN_NUMBER) return TAG_INT;
    if (run_len == 3'd2 && kw_live[0]) return TAG_FN;
    if (run_len == 3'd3 && kw_live[1]) return TAG_LET;
    return TAG_IDENT;
  endfunction

  function automatic void clear_run();
    run_kind = RUN_NONE;
    run_from = '0;
    run_len  = '0;
    kw_live  = 2'b11;
  endfunction

  function automatic void add_token(input tag_e tag, input logic [POS_WIDTH-1:0] s,
                                    input logic [POS_WIDTH-1:0] e);
    tok_t t;
    t.tag       = tag;
    t.start_pos = OUT_POS_WIDTH'(s);
    t.end_pos   = OUT_POS_WIDTH'(e);
    t.last      = 1'b0;
    token_q.push_back(t);
  endfunction

  // Expected tokens for one accepted byte
  function automatic void lex_byte(input logic [7:0] c);
    int   n;
    tok_t t;
    n = 0;
    if (run_kind == RUN_WORD && word_byte(c)) begin
      note_letter(c);
      cur_pos = pos_next(cur_pos);
      return;
    end
    if (run_kind == RUN_NUMBER && digit_byte(c)) begin
      if (run_len < 3'd4) run_len++;
      cur_pos = pos_next(cur_pos);
      return;
    end
    // A byte that does not continue the run closes it, then counts itself
    if (run_kind == RUN_WORD || run_kind == RUN_NUMBER) begin
      add_token(closed_run_tag(), run_from, cur_pos);
      n++;
    end
    clear_run();
    if (c == CH_NUL) begin
      add_token(TAG_EOF, cur_pos, cur_pos);
      n++;
      cur_pos = '0;
    end else if (is_space(c)) begin
      cur_pos = pos_next(cur_pos);
    end else if (word_byte(c)) begin
      run_kind = RUN_WORD;
      run_from = cur_pos;
      note_letter(c);
      cur_pos = pos_next(cur_pos);
    end else if (digit_byte(c)) begin
      run_kind = RUN_NUMBER;
      run_from = cur_pos;
      run_len  = 3'd1;
      cur_pos  = pos_next(cur_pos);
    end else begin
      add_token(byte_tag(c), cur_pos, pos_next(cur_pos));
      n++;
      cur_pos = pos_next(cur_pos);
    end
    if (n > 1) two_token_bytes++;
    if (n > 0) begin
      t = token_q.pop_back();
      t.last = 1'b1;
      token_q.push_back(t);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: pop with random stalls, long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic report(input string field, input int unsigned want, input int unsigned got);
    errors++;
    $display("%0t: %s mismatch: expected %0d actual %0d", $time, field, want, got);
  endtask

  // Compare every popped token with the oldest expectation
  always @(posedge clk_i) begin
    tok_t want;
    if (rst_ni && pop && !empty) begin
      if (token_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected token: expected none actual tag %0d start %0d end %0d",
                 $time, tag_o, start_pos_o, end_pos_o);
      end else begin
        want = token_q.pop_front();
        tokens_checked++;
        if (tag_o !== want.tag) report("tag", want.tag, tag_o);
        if (start_pos_o !== want.start_pos) report("start_pos", want.start_pos, start_pos_o);
        if (end_pos_o !== want.end_pos) report("end_pos", want.end_pos, end_pos_o);
        if (last_o !== want.last) report("last", want.last, last_o);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d tokens outstanding", $time, token_q.size());
      $display("tb_keyword_token_lexer: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Offer one byte, with random gaps, and wait until it is taken
  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    ch_i <= c;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    lex_byte(c);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Stop offering and wait until every expected token has been popped
  task automatic wait_for_tokens();
    push <= 1'b0;
    @(posedge clk_i);
    while (token_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  // One random piece of source text: mostly well-formed tokens, some noise
  task automatic send_random_piece();
    int unsigned kind;
    int unsigned len;
    int unsigned idx;
    kind = $urandom_range(99);
    if (kind < 12) begin
      if ($urandom_range(1) != 0) send_text("fn");
      else send_text("let");
    end else if (kind < 20) begin
      send_text(near_kw[$urandom_range(near_kw.size() - 1)]);
    end else if (kind < 38) begin
      len = $urandom_range(7, 1);
      repeat (len) begin
        idx = $urandom_range(52);
        if (idx < 26) send_byte(8'(CH_UPPER_A + idx));
        else if (idx < 52) send_byte(8'(CH_LOWER_A + idx - 26));
        else send_byte(CH_UNDER);
      end
    end else if (kind < 53) begin
      len = $urandom_range(6, 1);
      repeat (len) send_byte(8'(CH_ZERO + $urandom_range(9)));
    end else if (kind < 73) begin
      send_byte(punct_set[$urandom_range(punct_set.len() - 1)]);
    end else if (kind < 85) begin
      send_byte(space_set[$urandom_range(space_set.len() - 1)]);
    end else if (kind < 88) begin
      send_byte(CH_NUL);
    end else begin
      send_byte(8'($urandom_range(255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Keywords, identifiers and integers, and a run closed by a token
  task automatic test_keywords_and_runs();
    set_idling(0, 0);
    send_text("fn(let)9_Z}a0\t");
    wait_for_tokens();
  endtask

  // Every punctuation byte, the top byte value and the other separators
  task automatic test_single_byte_tokens();
    set_idling(35, 35);
    send_text(punct_set);
    send_byte(8'hFF);
    send_text("\r\n");
    wait_for_tokens();
  endtask

  // End of input with an open run, then again at position zero
  task automatic test_end_of_input();
    set_idling(0, 67);
    send_byte("7");
    send_byte(CH_NUL);
    send_byte(CH_NUL);
    wait_for_tokens();
  endtask

  // Positions along a longer line, runs closed by tokens, then end of input
  task automatic test_long_line();
    set_idling(0, 0);
    repeat (100) send_byte(CH_SPACE);
    send_text("ab;12345+x");
    send_byte(CH_NUL);
    wait_for_tokens();
  endtask

  // Hold the output off for a long stretch while bytes keep coming
  task automatic test_backpressure();
    set_idling(0, 0);
    hold_req <= hold_req + 1;
    repeat (20) send_text("a;");
    wait_for_tokens();
  endtask

  // Random text under one idling mix
  task automatic test_random_stream(input int unsigned send_pct, input int unsigned recv_pct);
    int unsigned first;
    set_idling(send_pct, recv_pct);
    first = bytes_sent;
    while (bytes_sent - first < BYTES_PER_PHASE) send_random_piece();
    wait_for_tokens();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_keywords_and_runs();
    test_single_byte_tokens();
    test_end_of_input();
    test_long_line();
    test_backpressure();
    test_random_stream(0, 0);
    test_random_stream(67, 0);
    test_random_stream(0, 67);
    test_random_stream(35, 35);

    // Let anything stray come out before the verdict
    set_idling(0, 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (token_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected tokens never arrived", $time, token_q.size());
    end
    $display("Sent %0d bytes, checked %0d tokens (%0d bytes gave two), %0d mismatches.",
             bytes_sent, tokens_checked, two_token_bytes, errors);
    $display("Covered keywords, runs, all single-byte tokens, end of input, a longer "
             , "line, a long output hold-off and four idle/stall mixes.");
    if (errors == 0) begin
      $display("tb_keyword_token_lexer: PASS");
    end else begin
      $display("tb_keyword_token_lexer: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/kwl_pkg.sv
rtl/kwl_front.sv
rtl/kwl_fifo.sv
rtl/kwl_back.sv
rtl/keyword_token_lexer.sv
tb/sv/tb_keyword_token_lexer.sv
